// File: rtl/aabb_thick_segment_overlap_macros.svh
// ---------------------------------------------------------------------------
// aabb_thick_segment_overlap assertion macros
// shared concurrent assertion forms for the overlap checker
// ---------------------------------------------------------------------------
`ifndef AABB_THICK_SEGMENT_OVERLAP_MACROS_SVH
`define AABB_THICK_SEGMENT_OVERLAP_MACROS_SVH

// checked only out of reset
`define ATSO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ATSO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/atso_pkg.sv
// ---------------------------------------------------------------------------
// atso_pkg
// types and constants of the box versus thick segment overlap pipeline
// ---------------------------------------------------------------------------
package atso_pkg;

    localparam int COORD_BITS    = 16;
    localparam int HALF_BITS     = COORD_BITS - 1;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int SUM_BITS      = COORD_BITS + 3;
    localparam int NORM_BITS     = 16;
    localparam int SHIFT_MAX     = (DIFF_BITS > NORM_BITS) ? DIFF_BITS - NORM_BITS : 0;
    localparam int SHIFT_BITS    = (SHIFT_MAX > 0) ? $clog2(SHIFT_MAX + 1) : 1;
    localparam int SQ_BITS       = 2 * NORM_BITS;
    localparam int L2_BITS       = SQ_BITS + 1;
    localparam int UNIT_BITS     = 15;
    localparam int REM_BITS      = SQ_BITS + 2 * UNIT_BITS;
    localparam int PL2_BITS      = L2_BITS + UNIT_BITS;
    localparam int TERM_BITS     = PL2_BITS + UNIT_BITS + 1;
    localparam int PROD_BITS     = DIFF_BITS + UNIT_BITS + 1;
    localparam int RPROD_BITS    = HALF_BITS + UNIT_BITS;
    localparam int CMP_BITS      = PROD_BITS + 3;

    localparam int FRONT_STAGES  = 3;
    localparam int ROOT_STAGES   = UNIT_BITS;
    localparam int BACK_STAGES   = 3;
    localparam int LATENCY       = FRONT_STAGES + ROOT_STAGES + BACK_STAGES;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [HALF_BITS-1:0]  t_half;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic        [L2_BITS-1:0]    t_l2;

    typedef struct packed {
        t_coord seg_start_x;
        t_coord seg_start_y;
        t_coord seg_end_x;
        t_coord seg_end_y;
        t_half  seg_half_width;
        t_coord box_center_x;
        t_coord box_center_y;
        t_half  box_half_w;
        t_half  box_half_h;
    } t_query;

    typedef struct packed {
        logic hit;
        logic degenerate;
    } t_result;

    typedef struct packed {
        t_diff dx;
        t_diff dy;
        t_diff vx;
        t_diff vy;
        t_half w;
        t_half hx;
        t_half hy;
        logic  degenerate;
        logic  broad;
        t_l2   l2;
    } t_carry;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [PL2_BITS-1:0]  p;
        logic [UNIT_BITS-1:0] q;
    } t_root;

    typedef struct packed {
        t_root x;
        t_root y;
    } t_root_pair;

endpackage

// File: rtl/atso_front.sv
// ---------------------------------------------------------------------------
// atso_front
// differences, broad phase, normalization and squared length
// ---------------------------------------------------------------------------
module atso_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  atso_pkg::t_query    i_query,
    output logic                o_valid,
    output atso_pkg::t_carry    o_carry,
    output atso_pkg::t_root_pair o_root
);

    localparam int SB = atso_pkg::SUM_BITS;
    localparam int DB = atso_pkg::DIFF_BITS;
    localparam int NB = atso_pkg::NORM_BITS;
    localparam int UB = atso_pkg::UNIT_BITS;

    // stage 1
    logic                 r_s1_valid;
    atso_pkg::t_carry     r_s1_carry;
    logic signed [SB-1:0] r_s1_sum_x, r_s1_sum_y;
    atso_pkg::t_carry     n_s1_carry;
    logic signed [SB-1:0] n_s1_sum_x, n_s1_sum_y;

    always_comb begin
        n_s1_carry            = '0;
        n_s1_carry.dx         = DB'(i_query.seg_end_x) - DB'(i_query.seg_start_x);
        n_s1_carry.dy         = DB'(i_query.seg_end_y) - DB'(i_query.seg_start_y);
        n_s1_carry.vx         = DB'(i_query.box_center_x) - DB'(i_query.seg_start_x);
        n_s1_carry.vy         = DB'(i_query.box_center_y) - DB'(i_query.seg_start_y);
        n_s1_carry.w          = i_query.seg_half_width;
        n_s1_carry.hx         = i_query.box_half_w;
        n_s1_carry.hy         = i_query.box_half_h;
        n_s1_carry.degenerate = (i_query.seg_start_x == i_query.seg_end_x) &&
                                (i_query.seg_start_y == i_query.seg_end_y);
        n_s1_sum_x = SB'(i_query.seg_start_x) + SB'(i_query.seg_end_x)
                   - (SB'(i_query.box_center_x) <<< 1);
        n_s1_sum_y = SB'(i_query.seg_start_y) + SB'(i_query.seg_end_y)
                   - (SB'(i_query.box_center_y) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_carry <= n_s1_carry;
        r_s1_sum_x <= n_s1_sum_x;
        r_s1_sum_y <= n_s1_sum_y;
    end

    // stage 2
    logic                 r_s2_valid;
    atso_pkg::t_carry     r_s2_carry;
    logic [NB-1:0]        r_s2_a, r_s2_b;
    atso_pkg::t_carry     n_s2_carry;
    logic [NB-1:0]        n_s2_a, n_s2_b;
    logic [DB-1:0]        adx, ady, mag;
    logic [SB-1:0]        abs_x, abs_y, lim_x, lim_y;
    logic [atso_pkg::SHIFT_BITS-1:0] sel;

    always_comb begin
        adx   = r_s1_carry.dx[DB-1] ? DB'(-r_s1_carry.dx) : DB'(r_s1_carry.dx);
        ady   = r_s1_carry.dy[DB-1] ? DB'(-r_s1_carry.dy) : DB'(r_s1_carry.dy);
        abs_x = r_s1_sum_x[SB-1] ? SB'(-r_s1_sum_x) : SB'(r_s1_sum_x);
        abs_y = r_s1_sum_y[SB-1] ? SB'(-r_s1_sum_y) : SB'(r_s1_sum_y);
        lim_x = SB'(adx) + (SB'(r_s1_carry.w) << 1) + (SB'(r_s1_carry.hx) << 1);
        lim_y = SB'(ady) + (SB'(r_s1_carry.w) << 1) + (SB'(r_s1_carry.hy) << 1);
        mag   = (adx > ady) ? adx : ady;
        sel   = '0;
        for (int i = atso_pkg::SHIFT_MAX; i >= 0; i--) begin
            if ((mag >> i) <= DB'((2 ** NB) - 1)) begin
                sel = atso_pkg::SHIFT_BITS'(i);
            end
        end
        n_s2_a           = NB'(adx >> sel);
        n_s2_b           = NB'(ady >> sel);
        n_s2_carry       = r_s1_carry;
        n_s2_carry.broad = (abs_x <= lim_x) && (abs_y <= lim_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_carry <= n_s2_carry;
        r_s2_a     <= n_s2_a;
        r_s2_b     <= n_s2_b;
    end

    // stage 3
    logic                     r_s3_valid;
    atso_pkg::t_carry         r_s3_carry;
    atso_pkg::t_root_pair     r_s3_root;
    atso_pkg::t_carry         n_s3_carry;
    atso_pkg::t_root_pair     n_s3_root;
    logic [atso_pkg::SQ_BITS-1:0] a2, b2;

    always_comb begin
        a2            = r_s2_a * r_s2_a;
        b2            = r_s2_b * r_s2_b;
        n_s3_carry    = r_s2_carry;
        n_s3_carry.l2 = atso_pkg::L2_BITS'(a2) + atso_pkg::L2_BITS'(b2);
        n_s3_root     = '0;
        n_s3_root.x.rem = {a2, (2 * UB)'(0)};
        n_s3_root.y.rem = {b2, (2 * UB)'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_carry <= n_s3_carry;
        r_s3_root  <= n_s3_root;
    end

    assign o_valid = r_s3_valid;
    assign o_carry = r_s3_carry;
    assign o_root  = r_s3_root;

endmodule

// File: rtl/atso_root_step.sv
// ---------------------------------------------------------------------------
// atso_root_step
// one bit of the unit direction search on both lanes
// ---------------------------------------------------------------------------
module atso_root_step #(
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  atso_pkg::t_carry     i_carry,
    input  atso_pkg::t_root_pair i_root,
    output logic                 o_valid,
    output atso_pkg::t_carry     o_carry,
    output atso_pkg::t_root_pair o_root
);

    localparam int TB = atso_pkg::TERM_BITS;

    // largest q with q*q*l2 <= a*a*2^30, one bit per stage
    function automatic atso_pkg::t_root root_step(atso_pkg::t_root cur, atso_pkg::t_l2 l2);
        logic [TB-1:0]   term;
        atso_pkg::t_root nxt;
        term = (TB'(cur.p) << (BIT + 1)) + (TB'(l2) << (2 * BIT));
        nxt  = cur;
        if (term <= TB'(cur.rem)) begin
            nxt.rem = cur.rem - atso_pkg::REM_BITS'(term);
            nxt.p   = cur.p + (atso_pkg::PL2_BITS'(l2) << BIT);
            nxt.q   = cur.q | (atso_pkg::UNIT_BITS'(1) << BIT);
        end
        return nxt;
    endfunction

    logic                 r_valid;
    atso_pkg::t_carry     r_carry;
    atso_pkg::t_root_pair r_root;
    atso_pkg::t_root_pair n_root;

    always_comb begin
        n_root.x = root_step(i_root.x, i_carry.l2);
        n_root.y = root_step(i_root.y, i_carry.l2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_carry <= i_carry;
        r_root  <= n_root;
    end

    assign o_valid = r_valid;
    assign o_carry = r_carry;
    assign o_root  = r_root;

endmodule

// File: rtl/atso_back.sv
// ---------------------------------------------------------------------------
// atso_back
// signed unit vector, axis projections and final hit decision
// ---------------------------------------------------------------------------
module atso_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  atso_pkg::t_carry     i_carry,
    input  atso_pkg::t_root_pair i_root,
    output logic                 o_valid,
    output atso_pkg::t_result    o_result
);

    localparam int UB  = atso_pkg::UNIT_BITS;
    localparam int PB  = atso_pkg::PROD_BITS;
    localparam int RB  = atso_pkg::RPROD_BITS;
    localparam int KB  = atso_pkg::CMP_BITS;
    localparam int DB  = atso_pkg::DIFF_BITS;

    // stage 1: signed components
    logic                   r_b1_valid;
    atso_pkg::t_carry       r_b1_carry;
    logic signed [UB:0]     r_ux, r_uy;
    logic [UB-1:0]          r_aux, r_auy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else begin
            r_b1_valid <= i_valid;
        end
        r_b1_carry <= i_carry;
        r_aux      <= i_root.x.q;
        r_auy      <= i_root.y.q;
        r_ux       <= i_carry.dx[DB-1] ? -$signed({1'b0, i_root.x.q})
                                       :  $signed({1'b0, i_root.x.q});
        r_uy       <= i_carry.dy[DB-1] ? -$signed({1'b0, i_root.y.q})
                                       :  $signed({1'b0, i_root.y.q});
    end

    // stage 2: products
    logic                   r_b2_valid;
    logic                   r_b2_degenerate, r_b2_broad;
    logic signed [PB-1:0]   r_vx_ux, r_vy_uy, r_vx_uy, r_vy_ux, r_dx_ux, r_dy_uy;
    logic [RB-1:0]          r_hx_aux, r_hy_auy, r_hx_auy, r_hy_aux;
    logic [RB-1:0]          r_wq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else begin
            r_b2_valid <= r_b1_valid;
        end
        r_b2_degenerate <= r_b1_carry.degenerate;
        r_b2_broad      <= r_b1_carry.broad;
        r_vx_ux  <= r_b1_carry.vx * r_ux;
        r_vy_uy  <= r_b1_carry.vy * r_uy;
        r_vx_uy  <= r_b1_carry.vx * r_uy;
        r_vy_ux  <= r_b1_carry.vy * r_ux;
        r_dx_ux  <= r_b1_carry.dx * r_ux;
        r_dy_uy  <= r_b1_carry.dy * r_uy;
        r_hx_aux <= r_b1_carry.hx * r_aux;
        r_hy_auy <= r_b1_carry.hy * r_auy;
        r_hx_auy <= r_b1_carry.hx * r_auy;
        r_hy_aux <= r_b1_carry.hy * r_aux;
        r_wq     <= RB'(r_b1_carry.w) << UB;
    end

    // stage 3: interval compares
    logic                   r_b3_valid;
    atso_pkg::t_result      r_result;
    atso_pkg::t_result      n_result;
    logic signed [KB-1:0]   c_dir, c_perp, r_dir, r_perp, lq, wq;
    logic                   dir_ok, perp_ok;

    always_comb begin
        c_dir   = KB'(r_vx_ux) + KB'(r_vy_uy);
        c_perp  = KB'(r_vy_ux) - KB'(r_vx_uy);
        lq      = KB'(r_dx_ux) + KB'(r_dy_uy);
        r_dir   = KB'(r_hx_aux) + KB'(r_hy_auy);
        r_perp  = KB'(r_hx_auy) + KB'(r_hy_aux);
        wq      = KB'(r_wq);
        dir_ok  = (c_dir + r_dir > -wq) && (c_dir - r_dir < lq + wq);
        perp_ok = (c_perp + r_perp > -wq) && (c_perp - r_perp < wq);
        n_result.degenerate = r_b2_degenerate;
        n_result.hit        = !r_b2_degenerate && r_b2_broad && dir_ok && perp_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b3_valid <= 1'b0;
        end else begin
            r_b3_valid <= r_b2_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_b3_valid;
    assign o_result = r_result;

endmodule

// File: rtl/aabb_thick_segment_overlap.sv
// ---------------------------------------------------------------------------
// aabb_thick_segment_overlap
// overlap query between an axis-aligned box and a thick line segment
// ---------------------------------------------------------------------------
// A query is taken in every cycle in which start is high; busy is always low.
// Each query gives exactly one result strobed on o_valid, after passing
// three front stages, fifteen stages of the unit direction search (one bit
// of the Q0.15 component per stage) and three projection stages. Results
// leave in query order and must be captured in the strobe cycle.
module aabb_thick_segment_overlap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  atso_pkg::t_query    i_query,
    output logic                o_valid,
    output atso_pkg::t_result   o_result
);

    localparam int NS = atso_pkg::ROOT_STAGES;

    logic                 v_valid [NS+1];
    atso_pkg::t_carry     v_carry [NS+1];
    atso_pkg::t_root_pair v_root  [NS+1];

    assign busy = 1'b0;

    atso_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_query (i_query),
        .o_valid (v_valid[0]),
        .o_carry (v_carry[0]),
        .o_root  (v_root[0])
    );

    for (genvar j = 0; j < NS; j++) begin : g_root
        atso_root_step #(
            .BIT (atso_pkg::UNIT_BITS - 1 - j)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_valid[j]),
            .i_carry (v_carry[j]),
            .i_root  (v_root[j]),
            .o_valid (v_valid[j+1]),
            .o_carry (v_carry[j+1]),
            .o_root  (v_root[j+1])
        );
    end

    atso_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_valid[NS]),
        .i_carry  (v_carry[NS]),
        .i_root   (v_root[NS]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// File: rtl/atso_checker.sv
// ---------------------------------------------------------------------------
// atso_checker
// port level checks of the overlap pipeline, bound to the top level
// ---------------------------------------------------------------------------
`include "aabb_thick_segment_overlap_macros.svh"

module atso_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input atso_pkg::t_query  i_query,
    input logic              o_valid,
    input atso_pkg::t_result o_result
);

    localparam int L = atso_pkg::LATENCY;

    logic xfer;
    logic zero_len;
    logic o_degen;

    assign xfer     = start && !busy;
    assign zero_len = (i_query.seg_start_x == i_query.seg_end_x) &&
                      (i_query.seg_start_y == i_query.seg_end_y);
    assign o_degen  = o_valid && o_result.degenerate;

    `ATSO_ASSERT_ALWAYS(a_reset_quiet, $past(!i_rst_n) |-> !o_valid, "strobe right after reset")
    `ATSO_ASSERT(a_no_invented, o_valid |-> $past(xfer, L), "result without a transfer")
    `ATSO_ASSERT(a_no_lost, xfer |-> ##L o_valid, "transfer without a result")
    `ATSO_ASSERT(a_degen_match, o_valid |-> o_result.degenerate == $past(zero_len, L), "degenerate mismatch")
    `ATSO_ASSERT(a_degen_no_hit, o_degen |-> !o_result.hit, "hit on zero length segment")

endmodule

bind aabb_thick_segment_overlap atso_checker u_atso_checker (.*);
